// File: design/psc_pkg.sv
// Package for the payload signature classifier: signature constants, class codes,
// register indexes, flag layout and the window compare function. No dependencies.
`default_nettype none

package psc_pkg;

  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned CfgW          = 16;
  localparam int unsigned HistDepth     = 8;
  localparam int unsigned WinBytes      = HistDepth + 1;
  localparam int unsigned WinW          = 8 * WinBytes;
  localparam int unsigned HvW           = 4;
  localparam int unsigned FlagW         = 9;

  localparam logic [CfgW-1:0] MsgLenRst   = 16'd517;
  localparam logic [CfgW-1:0] FileLenARst = 16'd260;
  localparam logic [CfgW-1:0] FileLenBRst = 16'd259;

  localparam logic [7:0] FileMarkByte = 8'h38;

  // newest byte sits in the low byte
  localparam logic [WinW-1:0] SigBase1   = 72'h69_72_61_6e_6c_6d_73;
  localparam logic [WinW-1:0] SigBase2   = 72'hc0_30;
  localparam logic [WinW-1:0] SigBase3   = 72'hff_01;
  localparam logic [WinW-1:0] SigBase4   = 72'h6e_6c_6d;
  localparam logic [WinW-1:0] SigBase5   = 72'h2e_69_72;
  localparam logic [WinW-1:0] SigKeyword = 72'h6d_65_73_73_65_6e_67_65_72;
  localparam logic [WinW-1:0] SigSocial  = 72'h72_75_62_69_6e_6f;
  localparam logic [WinW-1:0] SigService = 72'h73_65_72_76_69_63_65_73;

  localparam logic [HvW-1:0] LenBase1   = 4'd7;
  localparam logic [HvW-1:0] LenBase2   = 4'd2;
  localparam logic [HvW-1:0] LenBase3   = 4'd2;
  localparam logic [HvW-1:0] LenBase4   = 4'd3;
  localparam logic [HvW-1:0] LenBase5   = 4'd3;
  localparam logic [HvW-1:0] LenKeyword = 4'd9;
  localparam logic [HvW-1:0] LenSocial  = 4'd6;
  localparam logic [HvW-1:0] LenService = 4'd8;

  localparam int unsigned FlagPlain   = 5;
  localparam int unsigned FlagFile    = 6;
  localparam int unsigned FlagSocial  = 7;
  localparam int unsigned FlagService = 8;

  typedef enum logic [1:0] {
    CFG_MSG_LEN    = 2'd0,
    CFG_FILE_LEN_A = 2'd1,
    CFG_FILE_LEN_B = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CLS_NONE        = 3'd0,
    CLS_GENERIC     = 3'd1,
    CLS_MSG         = 3'd2,
    CLS_MSG_FILE    = 3'd3,
    CLS_SOCIAL      = 3'd4,
    CLS_SERVICE     = 3'd5,
    CLS_SOCIAL_FILE = 3'd6
  } class_e;

  typedef struct packed {
    logic base1;
    logic base2;
    logic base3;
    logic base4;
    logic base5;
    logic social;
    logic service;
    logic keyword;
  } psc_hit_t;

  function automatic logic sig_hit(input logic [WinW-1:0] win, input logic [HvW-1:0] hv,
                                   input logic [WinW-1:0] sig, input logic [HvW-1:0] slen);
    logic ok;
    ok = (({1'b0, hv} + 5'd1) >= {1'b0, slen});
    for (int k = 0; k < WinBytes; k++) begin
      if ((HvW'(k) < slen) && (win[8*k +: 8] != sig[8*k +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: design/psc_if.sv
// Valid/ready channel interfaces for input bytes and class code results.
// Depends on nothing.
`default_nettype none

interface psc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_tcp;
  logic       last_byte;

  modport source (output valid, output data_byte, output is_tcp, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input is_tcp, input last_byte,
                output ready);
endinterface

interface psc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] class_code;

  modport source (output valid, output class_code, input ready);
  modport sink (input valid, input class_code, output ready);
endinterface

`default_nettype wire

// File: design/psc_match.sv
// Byte history shift line and the eight signature comparators.
// Depends on psc_pkg.
`default_nettype none

module psc_match
  import psc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic     is_tcp_i,
  input  wire logic     last_byte_i,
  output psc_hit_t      hit_o
);

  logic [7:0]     hist_q [HistDepth];
  logic [HvW-1:0] hv_q, hv_d;
  logic [WinW-1:0] win;

  always_comb begin
    win[7:0] = data_byte_i;
    for (int k = 0; k < HistDepth; k++) begin
      win[8*(k+1) +: 8] = hist_q[k];
    end
  end

  always_comb begin
    hit_o.base1   = sig_hit(win, hv_q, SigBase1, LenBase1);
    hit_o.base2   = sig_hit(win, hv_q, SigBase2, LenBase2);
    hit_o.base3   = sig_hit(win, hv_q, SigBase3, LenBase3);
    hit_o.base4   = sig_hit(win, hv_q, SigBase4, LenBase4);
    hit_o.base5   = sig_hit(win, hv_q, SigBase5, LenBase5);
    hit_o.social  = sig_hit(win, hv_q, SigSocial, LenSocial);
    hit_o.service = sig_hit(win, hv_q, SigService, LenService);
    hit_o.keyword = sig_hit(win, hv_q, SigKeyword, LenKeyword);
  end

  always_comb begin
    hv_d = hv_q;
    if (step_i) begin
      if (is_tcp_i && !last_byte_i) begin
        hv_d = (hv_q == HvW'(HistDepth)) ? hv_q : hv_q + 1'b1;
      end else begin
        hv_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= '0;
    end else begin
      hv_q <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && is_tcp_i) begin
      hist_q[0] <= data_byte_i;
      for (int k = 1; k < HistDepth; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/psc_class.sv
// Sticky signature flags, keyword resolution, packet length counter and class
// selection. Depends on psc_pkg.
`default_nettype none

module psc_class
  import psc_pkg::*;
#(
  parameter int unsigned LengthBits = LengthBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            is_tcp_i,
  input  wire logic            last_byte_i,
  input  wire psc_hit_t        hit_i,
  input  wire logic [CfgW-1:0] msg_len_i,
  input  wire logic [CfgW-1:0] file_len_a_i,
  input  wire logic [CfgW-1:0] file_len_b_i,
  output class_e               class_o
);

  localparam int unsigned CmpW = (LengthBits > CfgW) ? LengthBits : CfgW;

  logic [FlagW-1:0]      flags_q, flags_d;
  logic                  pend_q, pend_d;
  logic [LengthBits-1:0] len_q, len_d, len_cur;
  logic [CmpW-1:0]       len_x;

  assign len_cur = (len_q == '1) ? len_q : len_q + 1'b1;
  assign len_x   = CmpW'(len_cur);

  always_comb begin
    flags_d = flags_q;
    pend_d  = pend_q;
    len_d   = len_cur;
    class_o = CLS_NONE;
    if (is_tcp_i) begin
      if (pend_q) begin
        if (data_byte_i == FileMarkByte) begin
          flags_d[FlagFile] = 1'b1;
        end else begin
          flags_d[FlagPlain] = 1'b1;
        end
      end
      pend_d = hit_i.keyword;
      flags_d[0]           = flags_d[0] | hit_i.base1;
      flags_d[1]           = flags_d[1] | hit_i.base2;
      flags_d[2]           = flags_d[2] | hit_i.base3;
      flags_d[3]           = flags_d[3] | hit_i.base4;
      flags_d[4]           = flags_d[4] | hit_i.base5;
      flags_d[FlagSocial]  = flags_d[FlagSocial] | hit_i.social;
      flags_d[FlagService] = flags_d[FlagService] | hit_i.service;
    end else begin
      if (pend_q) begin
        flags_d[FlagPlain] = 1'b1;
      end
      pend_d = 1'b0;
    end
    if (last_byte_i) begin
      if (pend_d) begin
        flags_d[FlagPlain] = 1'b1;
      end
      pend_d = 1'b0;
      len_d  = '0;
      if (!is_tcp_i || (flags_d[4:0] != 5'h1f)) begin
        class_o = CLS_NONE;
      end else if (flags_d[FlagPlain]) begin
        class_o = CLS_MSG;
      end else if (flags_d[FlagFile]) begin
        class_o = CLS_MSG_FILE;
      end else if (flags_d[FlagSocial]) begin
        class_o = CLS_SOCIAL;
      end else if (flags_d[FlagService]) begin
        class_o = CLS_SERVICE;
      end else if (len_x == CmpW'(msg_len_i)) begin
        class_o = CLS_MSG;
      end else if ((len_x == CmpW'(file_len_a_i)) || (len_x == CmpW'(file_len_b_i))) begin
        class_o = CLS_SOCIAL_FILE;
      end else begin
        class_o = CLS_GENERIC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      pend_q  <= 1'b0;
      len_q   <= '0;
    end else if (step_i) begin
      flags_q <= flags_d;
      pend_q  <= pend_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

// File: design/payload_signature_classifier_top.sv
// Top level of the payload signature classifier: input register, config registers,
// output register. Depends on psc_pkg, psc_if, psc_match and psc_class.
//
//   channel | dir | payload                              | beat
//   in_i    | in  | data_byte[8], is_tcp[1], last_byte[1] | one payload byte
//   out_o   | out | class_code[3]                        | one per last byte
//   cfg     | in  | cfg_we_i, cfg_idx_i[2], cfg_data_i[16] | one register write
//
// One byte per cycle, except while a last byte waits for the output register: a
// beat lands in the input register, the matcher and flag logic run on it there,
// and a last byte loads the output register when that register is free. Only a last
// byte waits for a free output register; other bytes pass through under output stall.
// Reset is asynchronous, active low; flags and lengths clear, config takes defaults.
`default_nettype none

module payload_signature_classifier_top
  import psc_pkg::*;
#(
  parameter int unsigned LengthBits = LengthBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  psc_in_if.sink               in_i,
  psc_out_if.source            out_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i
);

  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            in_tcp_q;
  logic            in_last_q;
  logic            out_vld_q;
  logic [2:0]      out_code_q;
  logic [CfgW-1:0] msg_len_q, file_len_a_q, file_len_b_q;
  logic            step;
  psc_hit_t        hit;
  class_e          cls;

  assign step        = in_vld_q && (!in_last_q || !out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || step;
  assign out_o.valid = out_vld_q;
  assign out_o.class_code = out_code_q;

  psc_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .is_tcp_i    (in_tcp_q),
    .last_byte_i (in_last_q),
    .hit_o       (hit)
  );

  psc_class #(
    .LengthBits (LengthBits)
  ) u_class (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_byte_q),
    .is_tcp_i     (in_tcp_q),
    .last_byte_i  (in_last_q),
    .hit_i        (hit),
    .msg_len_i    (msg_len_q),
    .file_len_a_i (file_len_a_q),
    .file_len_b_i (file_len_b_q),
    .class_o      (cls)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q    <= MsgLenRst;
      file_len_a_q <= FileLenARst;
      file_len_b_q <= FileLenBRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MSG_LEN:    msg_len_q    <= cfg_data_i;
        CFG_FILE_LEN_A: file_len_a_q <= cfg_data_i;
        CFG_FILE_LEN_B: file_len_b_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (step && in_last_q) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_tcp_q  <= in_i.is_tcp;
      in_last_q <= in_i.last_byte;
    end
    if (step && in_last_q) begin
      out_code_q <= cls;
    end
  end

endmodule

`default_nettype wire
